[rtl/core/hfpc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package hfpc_pkg;

  localparam int unsigned FRAME_LEN = 5;
  localparam int unsigned POS_W     = 3;
  localparam int unsigned SUM_W     = 10;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned VALUE_W   = 9;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_VALUE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_MASK   = 1'd1;

  localparam logic [POS_W-1:0] POS_FIRST = 3'd0;
  localparam logic [POS_W-1:0] POS_ID    = 3'd1;
  localparam logic [POS_W-1:0] POS_VAL_A = 3'd2;
  localparam logic [POS_W-1:0] POS_VAL_B = 3'd3;
  localparam logic [POS_W-1:0] POS_LAST  = 3'(FRAME_LEN - 1);

  typedef struct packed {
    logic [BYTE_W-1:0]  frame_id;
    logic [VALUE_W-1:0] frame_value;
    logic               checksum_ok;
  } result_t;

endpackage
`default_nettype wire

[rtl/core/hfpc_in_reg.sv]
`timescale 1ns / 1ps
`default_nettype none
module hfpc_in_reg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [hfpc_pkg::BYTE_W-1:0] in_rx_byte,
  output logic                            item_vld,
  output logic [hfpc_pkg::BYTE_W-1:0]     item_byte,
  input  wire logic                       item_take
);
  import hfpc_pkg::*;

  logic              vld_r;
  logic              vld_nxt;
  logic [BYTE_W-1:0] byte_r;

  assign in_ready  = !vld_r || item_take;
  assign item_vld  = vld_r;
  assign item_byte = byte_r;

  always_comb begin
    vld_nxt = vld_r;
    if (in_ready) begin
      vld_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule
`default_nettype wire

[rtl/core/hfpc_parse.sv]
`timescale 1ns / 1ps
`default_nettype none
module hfpc_parse (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [hfpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hfpc_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          item_vld,
  input  wire logic [hfpc_pkg::BYTE_W-1:0]    item_byte,
  output logic                               item_take,
  input  wire logic                          slot_free,
  output logic                               res_vld,
  output hfpc_pkg::result_t                  res
);
  import hfpc_pkg::*;

  logic [BYTE_W-1:0] header_r;
  logic [BYTE_W-1:0] mask_r;
  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  pos_nxt;
  logic              open_r;
  logic              open_nxt;
  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  sum_nxt;
  logic [BYTE_W-1:0] id_r;
  logic [BYTE_W-1:0] val_a_r;
  logic [BYTE_W-1:0] val_b_r;

  logic              start;
  logic [POS_W-1:0]  pos;
  logic              last;
  logic              emit;
  logic              ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= '0;
      mask_r   <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEADER_VALUE: header_r <= cfg_data;
        CFG_CHECK_MASK:   mask_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign start     = (item_byte == header_r) && !open_r;
  assign pos       = start ? POS_FIRST : pos_r;
  assign last      = (pos == POS_LAST);
  assign emit      = last && open_r;
  assign item_take = item_vld && (slot_free || !emit);
  assign res_vld   = item_take && emit;

  assign ok              = (item_byte == (sum_r[BYTE_W-1:0] & mask_r));
  assign res.checksum_ok = ok;
  assign res.frame_id    = ok ? id_r : '0;
  assign res.frame_value = ok ? ({1'b0, val_a_r} + {1'b0, val_b_r}) : '0;

  always_comb begin
    pos_nxt  = pos_r;
    open_nxt = open_r;
    sum_nxt  = sum_r;
    if (item_take) begin
      pos_nxt  = last ? POS_FIRST : pos + 1'b1;
      open_nxt = last ? 1'b0 : (open_r || start);
      if (pos == POS_FIRST) begin
        sum_nxt = {{(SUM_W-BYTE_W){1'b0}}, item_byte};
      end else if (!last) begin
        sum_nxt = sum_r + {{(SUM_W-BYTE_W){1'b0}}, item_byte};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_FIRST;
      open_r <= 1'b0;
      sum_r  <= '0;
    end else begin
      pos_r  <= pos_nxt;
      open_r <= open_nxt;
      sum_r  <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      case (pos)
        POS_ID:    id_r    <= item_byte;
        POS_VAL_A: val_a_r <= item_byte;
        POS_VAL_B: val_b_r <= item_byte;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/hfpc_out_reg.sv]
`timescale 1ns / 1ps
`default_nettype none
module hfpc_out_reg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        res_vld,
  input  wire hfpc_pkg::result_t           res,
  output logic                             slot_free,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [hfpc_pkg::BYTE_W-1:0]      out_frame_id,
  output logic [hfpc_pkg::VALUE_W-1:0]     out_frame_value,
  output logic                             out_checksum_ok
);
  import hfpc_pkg::*;

  logic    vld_r;
  logic    vld_nxt;
  result_t res_r;

  assign slot_free       = !vld_r || out_ready;
  assign out_valid       = vld_r;
  assign out_frame_id    = res_r.frame_id;
  assign out_frame_value = res_r.frame_value;
  assign out_checksum_ok = res_r.checksum_ok;

  always_comb begin
    vld_nxt = vld_r;
    if (slot_free) begin
      vld_nxt = res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld && slot_free) begin
      res_r <= res;
    end
  end

endmodule
`default_nettype wire

[rtl/core/header_frame_parser_checksum_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Five-byte frame parser with additive checksum. One byte is taken per request
// and a new byte can enter as the held one is taken: a byte enters an input
// register, the frame state (position, open flag, running sum, stored id and
// value bytes) advances as it moves on, and a frame result is written to an
// output register as its last byte is taken. A byte equal to header_value
// opens a frame only when none is open; the fifth byte of an open frame yields
// one result with checksum_ok set when it equals the sum of bytes 0 to 3 masked
// by check_mask; on a mismatch frame_id and frame_value read as zero. Bytes
// seen with no frame open produce nothing. Write configuration only while idle.
module header_frame_parser_checksum_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [hfpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hfpc_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [hfpc_pkg::BYTE_W-1:0]    in_rx_byte,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [hfpc_pkg::BYTE_W-1:0]         out_frame_id,
  output logic [hfpc_pkg::VALUE_W-1:0]        out_frame_value,
  output logic                               out_checksum_ok
);
  import hfpc_pkg::*;

  logic              item_vld;
  logic [BYTE_W-1:0] item_byte;
  logic              item_take;
  logic              slot_free;
  logic              res_vld;
  result_t           res;

  hfpc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .item_vld   (item_vld),
    .item_byte  (item_byte),
    .item_take  (item_take)
  );

  hfpc_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item_vld  (item_vld),
    .item_byte (item_byte),
    .item_take (item_take),
    .slot_free (slot_free),
    .res_vld   (res_vld),
    .res       (res)
  );

  hfpc_out_reg u_out_reg (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_vld         (res_vld),
    .res             (res),
    .slot_free       (slot_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_frame_id    (out_frame_id),
    .out_frame_value (out_frame_value),
    .out_checksum_ok (out_checksum_ok)
  );

endmodule
`default_nettype wire
